// ----- hdl/clt_pkg.sv -----
// Package for the command line tokenizer: widths, constants, parse modes
// and configuration register indexes. No dependencies.
package clt_pkg;

    // Field widths
    localparam int CP_W  = 21;
    localparam int CNT_W = 7;
    localparam int IDX_W = 6;
    localparam int CFG_IDX_W = 3;

    // Largest argument count the block will ever open
    localparam logic [CNT_W-1:0] ARG_LIMIT = CNT_W'(64);

    // Character codes the parser looks at
    localparam logic [CP_W-1:0] CH_NUL    = CP_W'(0);
    localparam logic [CP_W-1:0] CH_TAB    = CP_W'(9);
    localparam logic [CP_W-1:0] CH_LF     = CP_W'(10);
    localparam logic [CP_W-1:0] CH_CR     = CP_W'(13);
    localparam logic [CP_W-1:0] CH_SPACE  = CP_W'(32);
    localparam logic [CP_W-1:0] CH_DQUOTE = CP_W'(34);
    localparam logic [CP_W-1:0] CH_SQUOTE = CP_W'(39);
    localparam logic [CP_W-1:0] CH_STAR   = CP_W'(42);
    localparam logic [CP_W-1:0] CH_COMMA  = CP_W'(44);
    localparam logic [CP_W-1:0] CH_QMARK  = CP_W'(63);
    localparam logic [CP_W-1:0] CH_BSLASH = CP_W'(92);
    localparam logic [CP_W-1:0] CH_OBRACE = CP_W'(123);
    localparam logic [CP_W-1:0] CH_CBRACE = CP_W'(125);

    // Register reset values
    localparam logic [CNT_W-1:0] RST_MAX_ARGS   = CNT_W'(64);
    localparam logic [CP_W-1:0]  RST_STAR_TOK   = CP_W'(57345);
    localparam logic [CP_W-1:0]  RST_QMARK_TOK  = CP_W'(57346);
    localparam logic [CP_W-1:0]  RST_OBRACE_TOK = CP_W'(57347);
    localparam logic [CP_W-1:0]  RST_CBRACE_TOK = CP_W'(57348);
    localparam logic [CP_W-1:0]  RST_COMMA_TOK  = CP_W'(57349);

    // Parser modes
    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'd0,
        MODE_ARG     = 3'd1,
        MODE_ESCAPE  = 3'd2,
        MODE_DQUOTE  = 3'd3,
        MODE_SQUOTE  = 3'd4
    } t_mode;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ARGS     = 3'd0,
        CFG_STAR_TOKEN   = 3'd1,
        CFG_QMARK_TOKEN  = 3'd2,
        CFG_OBRACE_TOKEN = 3'd3,
        CFG_CBRACE_TOKEN = 3'd4,
        CFG_COMMA_TOKEN  = 3'd5
    } t_cfg_idx;

endpackage

// ----- hdl/clt_ifs.sv -----
// Valid/ready channel interfaces for the command line tokenizer.
// Depends on clt_pkg for field widths.
interface clt_in_if;
    logic                         valid;
    logic                         ready;
    logic [clt_pkg::CP_W-1:0]     codepoint;

    modport source (output valid, output codepoint, input ready);
    modport sink   (input valid, input codepoint, output ready);
endinterface

interface clt_out_if;
    logic                         valid;
    logic                         ready;
    logic [clt_pkg::CP_W-1:0]     out_char;
    logic                         has_char;
    logic [clt_pkg::IDX_W-1:0]    arg_index;
    logic                         end_of_arg;
    logic                         end_of_line;
    logic [clt_pkg::CNT_W-1:0]    arg_count;

    modport source (output valid, output out_char, output has_char, output arg_index,
                    output end_of_arg, output end_of_line, output arg_count, input ready);
    modport sink   (input valid, input out_char, input has_char, input arg_index,
                    input end_of_arg, input end_of_line, input arg_count, output ready);
endinterface

// ----- hdl/command_line_tokenizer_core.sv -----
// Command line tokenizer core: shell-style argument splitter, one codepoint per item.
// Depends on clt_pkg and the channel interfaces in clt_ifs.sv.
//
// Usage:
//   i_cp carries one codepoint per item; codepoint 0 ends the line.
//   o_res carries at most one result per input item: a kept character with its
//   argument index, an end-of-argument mark, or the end-of-line result with the
//   final argument count. Blanks between arguments, opening and closing quote marks,
//   unquoted backslashes and everything past the argument limit produce no result.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while the
//   block is idle; writes to unused indexes are ignored.
// Timing:
//   One item per cycle sustained while the receiver takes results. A result appears
//   on o_res in the cycle after its item is accepted; the mode update and token mapping
//   sit between the input handshake and the single result register.
//   When the receiver stalls, the result register holds and i_cp.ready drops
//   until the result is taken; ready returns in the cycle the result leaves.
// Reset:
//   Synchronous, active low. Returns the parser to between-arguments with a zero
//   count, empties the result register and restores the register defaults.
module command_line_tokenizer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [clt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [clt_pkg::CP_W-1:0]        i_cfg_data,
    clt_in_if.sink                          i_cp,
    clt_out_if.source                       o_res
);

    // Configuration registers
    logic [clt_pkg::CNT_W-1:0] r_max_args;
    logic [clt_pkg::CP_W-1:0]  r_star_tok;
    logic [clt_pkg::CP_W-1:0]  r_qmark_tok;
    logic [clt_pkg::CP_W-1:0]  r_obrace_tok;
    logic [clt_pkg::CP_W-1:0]  r_cbrace_tok;
    logic [clt_pkg::CP_W-1:0]  r_comma_tok;

    // Parser state
    clt_pkg::t_mode            r_mode, n_mode;
    logic [clt_pkg::CNT_W-1:0] r_count, n_count;

    // Result register
    logic                      r_valid;
    logic [clt_pkg::CP_W-1:0]  r_char, n_char;
    logic                      r_has, n_has;
    logic [clt_pkg::IDX_W-1:0] r_idx, n_idx;
    logic                      r_eoa, n_eoa;
    logic                      r_eol, n_eol;
    logic [clt_pkg::CNT_W-1:0] r_cnt_out, n_cnt_out;
    logic                      n_emit;

    // Working signals
    logic                      accept;
    logic                      blank;
    logic                      do_char;
    logic                      between_at_put;
    logic [clt_pkg::CNT_W-1:0] limit;
    logic [clt_pkg::CP_W-1:0]  c;
    logic [clt_pkg::CP_W-1:0]  mapped;
    logic [clt_pkg::CNT_W-1:0] idx_wide;

    assign i_cp.ready = !r_valid || o_res.ready;
    assign accept     = i_cp.valid && i_cp.ready;
    assign c          = i_cp.codepoint;

    assign blank = (c == clt_pkg::CH_SPACE) || (c == clt_pkg::CH_TAB)
                || (c == clt_pkg::CH_CR) || (c == clt_pkg::CH_LF);
    assign limit = (r_max_args < clt_pkg::ARG_LIMIT) ? r_max_args : clt_pkg::ARG_LIMIT;

    // Replace unquoted special characters by their tokens
    always_comb begin
        unique case (c)
            clt_pkg::CH_STAR:   mapped = r_star_tok;
            clt_pkg::CH_QMARK:  mapped = r_qmark_tok;
            clt_pkg::CH_OBRACE: mapped = r_obrace_tok;
            clt_pkg::CH_CBRACE: mapped = r_cbrace_tok;
            clt_pkg::CH_COMMA:  mapped = r_comma_tok;
            default:            mapped = c;
        endcase
    end

    // Next mode, count and result for one item
    always_comb begin
        n_mode         = r_mode;
        n_count        = r_count;
        n_emit         = 1'b0;
        n_char         = '0;
        n_has          = 1'b0;
        n_eoa          = 1'b0;
        n_eol          = 1'b0;
        do_char        = 1'b0;
        between_at_put = 1'b0;
        n_cnt_out      = r_count;

        if (c == clt_pkg::CH_NUL) begin
            // end of line closes any open argument and resets the parser
            n_emit         = 1'b1;
            n_eoa          = (r_mode != clt_pkg::MODE_BETWEEN);
            n_eol          = 1'b1;
            between_at_put = (r_mode == clt_pkg::MODE_BETWEEN);
            n_mode         = clt_pkg::MODE_BETWEEN;
            n_count        = '0;
        end else begin
            unique case (r_mode)
                clt_pkg::MODE_ESCAPE: begin
                    n_mode = clt_pkg::MODE_ARG;
                    n_emit = 1'b1;
                    n_has  = 1'b1;
                    n_char = c;
                end
                clt_pkg::MODE_DQUOTE: begin
                    if (c == clt_pkg::CH_DQUOTE) begin
                        n_mode = clt_pkg::MODE_ARG;
                    end else begin
                        n_emit = 1'b1;
                        n_has  = 1'b1;
                        n_char = c;
                    end
                end
                clt_pkg::MODE_SQUOTE: begin
                    if (c == clt_pkg::CH_SQUOTE) begin
                        n_mode = clt_pkg::MODE_ARG;
                    end else begin
                        n_emit = 1'b1;
                        n_has  = 1'b1;
                        n_char = c;
                    end
                end
                clt_pkg::MODE_ARG: begin
                    if (blank) begin
                        n_emit = 1'b1;
                        n_eoa  = 1'b1;
                        n_mode = clt_pkg::MODE_BETWEEN;
                    end else begin
                        do_char = 1'b1;
                    end
                end
                default: begin
                    // between arguments: open a new one unless blank or out of slots
                    if (blank || (r_count >= limit)) begin
                        n_mode = clt_pkg::MODE_BETWEEN;
                    end else begin
                        n_count = r_count + 1'b1;
                        n_mode  = clt_pkg::MODE_ARG;
                        do_char = 1'b1;
                    end
                end
            endcase

            // Plain character inside an argument: quote, escape or keep
            if (do_char) begin
                priority if (c == clt_pkg::CH_BSLASH) begin
                    n_mode = clt_pkg::MODE_ESCAPE;
                end else if (c == clt_pkg::CH_DQUOTE) begin
                    n_mode = clt_pkg::MODE_DQUOTE;
                end else if (c == clt_pkg::CH_SQUOTE) begin
                    n_mode = clt_pkg::MODE_SQUOTE;
                end else begin
                    n_emit = 1'b1;
                    n_has  = 1'b1;
                    n_char = mapped;
                end
            end
            n_cnt_out = n_count;
        end

        // Argument index of this result
        idx_wide = (between_at_put || (n_cnt_out == '0)) ? '0 : (n_cnt_out - 1'b1);
        n_idx    = idx_wide[clt_pkg::IDX_W-1:0];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_args   <= clt_pkg::RST_MAX_ARGS;
            r_star_tok   <= clt_pkg::RST_STAR_TOK;
            r_qmark_tok  <= clt_pkg::RST_QMARK_TOK;
            r_obrace_tok <= clt_pkg::RST_OBRACE_TOK;
            r_cbrace_tok <= clt_pkg::RST_CBRACE_TOK;
            r_comma_tok  <= clt_pkg::RST_COMMA_TOK;
        end else if (i_cfg_we) begin
            unique case (clt_pkg::t_cfg_idx'(i_cfg_idx))
                clt_pkg::CFG_MAX_ARGS:     r_max_args   <= i_cfg_data[clt_pkg::CNT_W-1:0];
                clt_pkg::CFG_STAR_TOKEN:   r_star_tok   <= i_cfg_data;
                clt_pkg::CFG_QMARK_TOKEN:  r_qmark_tok  <= i_cfg_data;
                clt_pkg::CFG_OBRACE_TOKEN: r_obrace_tok <= i_cfg_data;
                clt_pkg::CFG_CBRACE_TOKEN: r_cbrace_tok <= i_cfg_data;
                clt_pkg::CFG_COMMA_TOKEN:  r_comma_tok  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Parser state: advance on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= clt_pkg::MODE_BETWEEN;
            r_count <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    // Result valid: load on an emitting item, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= n_emit;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_char    <= n_char;
            r_has     <= n_has;
            r_idx     <= n_idx;
            r_eoa     <= n_eoa;
            r_eol     <= n_eol;
            r_cnt_out <= n_cnt_out;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.out_char    = r_char;
    assign o_res.has_char    = r_has;
    assign o_res.arg_index   = r_idx;
    assign o_res.end_of_arg  = r_eoa;
    assign o_res.end_of_line = r_eol;
    assign o_res.arg_count   = r_cnt_out;

endmodule
